// ===== rtl/rrts_pkg.sv =====
// rrts_pkg: shared constants, codes and control structs of the thread scheduler.
// No dependencies; imported by every rrts module and the scheduler core.
`timescale 1ns / 1ps
package rrts_pkg;

    localparam int MAX_THREADS_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int ID_W            = 6;
    localparam int CMD_W           = 3;
    localparam int STAT_W          = 3;
    localparam int QUANTA_W        = 16;
    localparam int OUT_CNT_W       = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_SPAWN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TERM   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_MANY  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_ID     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MAIN_OP   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BAD_INPUT = 3'd5;
    localparam logic [STAT_W-1:0] STAT_MAIN_EXIT = 3'd6;

    // thread modes
    localparam logic [1:0] MODE_READY    = 2'd0;
    localparam logic [1:0] MODE_RUNNING  = 2'd1;
    localparam logic [1:0] MODE_BLOCKED  = 2'd2;
    localparam logic [1:0] MODE_SLEEPING = 2'd3;

    // pending runner actions
    localparam logic [1:0] PEND_ROUTINE = 2'd0;
    localparam logic [1:0] PEND_SLEEP   = 2'd1;
    localparam logic [1:0] PEND_BLOCK   = 2'd2;
    localparam logic [1:0] PEND_REMOVE  = 2'd3;

    typedef enum logic [2:0] {
        COP_NOP,
        COP_RESET,
        COP_SPAWN,
        COP_FREE,
        COP_MODE,
        COP_SLEEP,
        COP_DEC,
        COP_DISPATCH
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [ID_W-1:0]       tid;
        logic [1:0]            mode;
        logic [QUANTA_W-1:0]   quanta;
    } t_cell_cmd;

    typedef struct packed {
        logic            clear;
        logic            push;
        logic            remove;
        logic [ID_W-1:0] id;
    } t_queue_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_SETTLE,
        ST_DISPATCH,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/rrts_thread_cell.sv =====
// rrts_thread_cell: per-thread state (slot used, mode, quanta count, wake countdown).
// Depends on rrts_pkg for the broadcast cell command.
`timescale 1ns / 1ps
module rrts_thread_cell #(
    parameter int IDX         = 0,
    parameter int COUNT_WIDTH = rrts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrts_pkg::t_cell_cmd           i_cmd,
    output logic                          o_used,
    output logic [1:0]                    o_mode,
    output logic [COUNT_WIDTH-1:0]        o_runs,
    output logic [rrts_pkg::QUANTA_W-1:0] o_wake
);
    import rrts_pkg::*;

    logic                   r_used;
    logic [1:0]             r_mode;
    logic [COUNT_WIDTH-1:0] r_runs;
    logic [QUANTA_W-1:0]    r_wake;
    logic [QUANTA_W-1:0]    n_wake_dec;
    logic                   hit;

    assign hit        = (i_cmd.tid == ID_W'(IDX));
    assign n_wake_dec = (r_wake != '0) ? r_wake - 1'b1 : r_wake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == COP_RESET) begin
            r_used <= (IDX == 0);
            r_mode <= (IDX == 0) ? MODE_RUNNING : MODE_READY;
            r_runs <= (IDX == 0) ? COUNT_WIDTH'(1) : '0;
            r_wake <= '0;
        end else if (hit) begin
            case (i_cmd.op)
                COP_SPAWN, COP_FREE: begin
                    r_used <= (i_cmd.op == COP_SPAWN);
                    r_mode <= MODE_READY;
                    r_runs <= '0;
                    r_wake <= '0;
                end
                COP_MODE: begin
                    r_mode <= i_cmd.mode;
                    r_wake <= '0;
                end
                COP_SLEEP: begin
                    r_mode <= MODE_SLEEPING;
                    r_wake <= i_cmd.quanta;
                end
                COP_DEC: begin
                    r_wake <= n_wake_dec;
                    if (n_wake_dec == '0) begin
                        r_mode <= MODE_READY;
                    end
                end
                COP_DISPATCH: begin
                    r_mode <= MODE_RUNNING;
                    if (r_runs != '1) begin
                        r_runs <= r_runs + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_used = r_used;
    assign o_mode = r_mode;
    assign o_runs = r_runs;
    assign o_wake = r_wake;

endmodule

// ===== rtl/rrts_queue_cell.sv =====
// rrts_queue_cell: one entry of an ordered thread list; removal shifts from the neighbor.
// Depends on rrts_pkg for the queue control struct.
`timescale 1ns / 1ps
module rrts_queue_cell #(
    parameter int IDX   = 0,
    parameter int TID_W = 4
) (
    input  logic                   i_clk,
    input  rrts_pkg::t_queue_ctl   i_ctl,
    input  logic [TID_W:0]         i_count,
    input  logic [TID_W-1:0]       i_next,
    input  logic                   i_hit,
    output logic [TID_W-1:0]       o_entry,
    output logic                   o_hit
);
    import rrts_pkg::*;

    logic [TID_W-1:0] r_entry;
    logic             match;

    assign match = i_ctl.remove && (ID_W'(r_entry) == i_ctl.id)
                   && ((TID_W+1)'(IDX) < i_count);
    // once a match is seen, every later entry moves down one place
    assign o_hit = i_hit | match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && i_count == (TID_W+1)'(IDX)) begin
            r_entry <= i_ctl.id[TID_W-1:0];
        end else if (o_hit) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/rrts_queue.sv =====
// rrts_queue: ordered thread list built as a chain of rrts_queue_cell plus a fill count.
// Depends on rrts_pkg and rrts_queue_cell.
`timescale 1ns / 1ps
module rrts_queue #(
    parameter int DEPTH = rrts_pkg::MAX_THREADS_DEF,
    parameter int TID_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrts_pkg::t_queue_ctl i_ctl,
    input  logic [TID_W-1:0]     i_rd_idx,
    output logic [TID_W-1:0]     o_rd_entry,
    output logic [TID_W-1:0]     o_head,
    output logic [TID_W:0]       o_count
);
    import rrts_pkg::*;

    logic [TID_W:0]   r_count;
    logic [TID_W:0]   n_count;
    logic [TID_W-1:0] entry [DEPTH];
    logic             hit   [DEPTH+1];

    assign hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [TID_W-1:0] nxt;
        if (g == DEPTH - 1) begin : g_last
            assign nxt = '0;
        end else begin : g_mid
            assign nxt = entry[g+1];
        end
        rrts_queue_cell #(
            .IDX   (g),
            .TID_W (TID_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (r_count),
            .i_next  (nxt),
            .i_hit   (hit[g]),
            .o_entry (entry[g]),
            .o_hit   (hit[g+1])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.push && r_count < (TID_W+1)'(DEPTH)) begin
            n_count = r_count + 1'b1;
        end else if (hit[DEPTH]) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_rd_entry = entry[i_rd_idx];
    assign o_head     = entry[0];
    assign o_count    = r_count;

endmodule

// ===== rtl/round_robin_thread_scheduler_core.sv =====
// round_robin_thread_scheduler_core: top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_thread_cell and rrts_queue.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid / o_stall) carries one command word: cmd, thread id and
//   sleep quanta. Output channel (o_valid / i_stall) returns one status word per
//   command. i_cfg_wr_en writes the thread limit; write it only while idle.
//   Thread state lives in a row of per-thread cells; the ready queue and the
//   sleep list are chains of entry cells that close up on removal.
//   A command other than tick goes through EXEC and DONE to the output register.
//   A tick walks the sleep list one entry per cycle, then SETTLE and DISPATCH run.
//   With the output taken, the next command is accepted once the state is idle.
//   One command is in work at a time; a finished result sits in the output
//   register, so the next command may be accepted while it waits there.
//   Holding i_stall keeps the result word stable and, once a second result is
//   done, holds o_stall high.
//   Reset (synchronous, i_rst_n low): thread 0 running, queues empty, limit at
//   the built maximum, total quanta one. No result is pending after reset.
module round_robin_thread_scheduler_core #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
    parameter int COUNT_WIDTH = rrts_pkg::COUNT_WIDTH_DEF,
    parameter int TID_W       = $clog2(MAX_THREADS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [TID_W:0]                 i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rrts_pkg::CMD_W-1:0]     i_cmd,
    input  logic [rrts_pkg::ID_W-1:0]      i_thread_id,
    input  logic [rrts_pkg::QUANTA_W-1:0]  i_sleep_quanta,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rrts_pkg::STAT_W-1:0]    o_status,
    output logic [TID_W-1:0]               o_assigned_id,
    output logic [TID_W:0]                 o_running_id,
    output logic [rrts_pkg::OUT_CNT_W-1:0] o_total_quanta,
    output logic [rrts_pkg::OUT_CNT_W-1:0] o_thread_quanta,
    output logic [rrts_pkg::QUANTA_W-1:0]  o_sleep_left
);
    import rrts_pkg::*;

    localparam int RUN_W = TID_W + 1;
    localparam logic [RUN_W-1:0] NO_RUNNER = RUN_W'(MAX_THREADS);

    t_state r_state, n_state;

    logic [RUN_W-1:0]        r_limit;
    logic [CMD_W-1:0]        r_cmd;
    logic [ID_W-1:0]         r_id;
    logic [QUANTA_W-1:0]     r_q;
    logic [RUN_W-1:0]        r_runner, n_runner;
    logic [1:0]              r_pend, n_pend;
    logic [COUNT_WIDTH-1:0]  r_total, n_total;
    logic [RUN_W-1:0]        r_used_cnt, n_used_cnt;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [TID_W-1:0]        r_asg, n_asg;
    logic [RUN_W-1:0]        r_shown, n_shown;
    logic [RUN_W-1:0]        r_walk, n_walk;
    logic [RUN_W-1:0]        r_old, n_old;

    logic                    r_ov;
    logic [STAT_W-1:0]       r_o_status;
    logic [TID_W-1:0]        r_o_asg;
    logic [RUN_W-1:0]        r_o_run;
    logic [OUT_CNT_W-1:0]    r_o_total;
    logic [OUT_CNT_W-1:0]    r_o_tq;
    logic [QUANTA_W-1:0]     r_o_sl;

    t_cell_cmd               cell_cmd;
    t_queue_ctl              rq_ctl, sq_ctl;

    logic                    w_used [MAX_THREADS];
    logic [1:0]              w_mode [MAX_THREADS];
    logic [COUNT_WIDTH-1:0]  w_runs [MAX_THREADS];
    logic [QUANTA_W-1:0]     w_wake [MAX_THREADS];

    logic [TID_W-1:0]        sel;
    logic                    rd_used;
    logic [1:0]              rd_mode;
    logic [COUNT_WIDTH-1:0]  rd_runs;
    logic [QUANTA_W-1:0]     rd_wake;
    logic [63:0]             rd_runs64;
    logic [63:0]             total64;

    logic [TID_W-1:0]        rq_head, sq_entry, rq_unused;
    logic [RUN_W-1:0]        rq_count, sq_count;
    logic [TID_W-1:0]        sq_head_unused;

    logic [RUN_W-1:0]        lim_eff;
    logic                    accept, load_out;
    logic [STAT_W-1:0]       chk;
    logic                    is_runner;
    logic                    free_found;
    logic [TID_W-1:0]        free_id;
    logic                    shown_ok;

    // ---------------- cells and queues ----------------
    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_thread
        rrts_thread_cell #(
            .IDX         (g),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cell_cmd),
            .o_used  (w_used[g]),
            .o_mode  (w_mode[g]),
            .o_runs  (w_runs[g]),
            .o_wake  (w_wake[g])
        );
    end

    rrts_queue #(
        .DEPTH (MAX_THREADS),
        .TID_W (TID_W)
    ) u_ready_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (rq_ctl),
        .i_rd_idx   (TID_W'(0)),
        .o_rd_entry (rq_unused),
        .o_head     (rq_head),
        .o_count    (rq_count)
    );

    rrts_queue #(
        .DEPTH (MAX_THREADS),
        .TID_W (TID_W)
    ) u_sleep_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sq_ctl),
        .i_rd_idx   (r_walk[TID_W-1:0]),
        .o_rd_entry (sq_entry),
        .o_head     (sq_head_unused),
        .o_count    (sq_count)
    );

    // ---------------- shared read port into the thread cells ----------------
    always_comb begin
        case (r_state)
            ST_EXEC:   sel = r_id[TID_W-1:0];
            ST_WALK:   sel = sq_entry;
            default:   sel = r_shown[TID_W-1:0];
        endcase
    end

    assign rd_used   = w_used[sel];
    assign rd_mode   = w_mode[sel];
    assign rd_runs   = w_runs[sel];
    assign rd_wake   = w_wake[sel];
    assign rd_runs64 = 64'(rd_runs);
    assign total64   = 64'(r_total);

    assign lim_eff = (r_limit == '0) ? RUN_W'(1) :
                     (r_limit > RUN_W'(MAX_THREADS)) ? RUN_W'(MAX_THREADS) : r_limit;

    assign chk = (int'(r_id) >= int'(lim_eff)) ? STAT_RANGE :
                 (!rd_used) ? STAT_NO_ID : STAT_OK;
    assign is_runner = (int'(r_id) == int'(r_runner));

    always_comb begin
        free_found = 1'b0;
        free_id    = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (!free_found && RUN_W'(i) < lim_eff && !w_used[i]) begin
                free_found = 1'b1;
                free_id    = TID_W'(i);
            end
        end
    end

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_DONE) && (!r_ov || !i_stall);
    assign shown_ok = (r_shown < NO_RUNNER) && rd_used;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (accept) n_state = ST_EXEC;
            ST_EXEC:     n_state = (r_cmd == CMD_TICK) ? ST_WALK : ST_DONE;
            ST_WALK:     if (r_walk >= sq_count) n_state = ST_SETTLE;
            ST_SETTLE:   n_state = ST_DISPATCH;
            ST_DISPATCH: n_state = ST_DONE;
            ST_DONE:     if (load_out) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------- command execution ----------------
    always_comb begin
        n_runner   = r_runner;
        n_pend     = r_pend;
        n_total    = r_total;
        n_used_cnt = r_used_cnt;
        n_status   = r_status;
        n_asg      = r_asg;
        n_shown    = r_shown;
        n_walk     = r_walk;
        n_old      = r_old;
        cell_cmd   = '{op: COP_NOP, tid: '0, mode: MODE_READY, quanta: r_q};
        rq_ctl     = '0;
        sq_ctl     = '0;

        case (r_state)
            ST_EXEC: begin
                n_status = STAT_OK;
                n_asg    = '0;
                n_shown  = NO_RUNNER;
                case (r_cmd)
                    CMD_SPAWN: begin
                        if (r_used_cnt >= lim_eff || !free_found) begin
                            n_status = STAT_TOO_MANY;
                        end else begin
                            cell_cmd.op  = COP_SPAWN;
                            cell_cmd.tid = ID_W'(free_id);
                            rq_ctl.push  = 1'b1;
                            rq_ctl.id    = ID_W'(free_id);
                            n_asg        = free_id;
                            n_shown      = RUN_W'(free_id);
                            n_used_cnt   = r_used_cnt + 1'b1;
                        end
                    end
                    CMD_TERM: begin
                        if (r_id == '0) begin
                            cell_cmd.op  = COP_RESET;
                            rq_ctl.clear = 1'b1;
                            sq_ctl.clear = 1'b1;
                            n_runner     = '0;
                            n_pend       = PEND_ROUTINE;
                            n_total      = COUNT_WIDTH'(1);
                            n_used_cnt   = RUN_W'(1);
                            n_status     = STAT_MAIN_EXIT;
                            n_shown      = '0;
                        end else begin
                            n_status = chk;
                            if (chk == STAT_OK) begin
                                if (is_runner) begin
                                    n_runner = NO_RUNNER;
                                    n_pend   = PEND_REMOVE;
                                end else if (rd_mode == MODE_READY) begin
                                    rq_ctl.remove = 1'b1;
                                    rq_ctl.id     = r_id;
                                end else if (rd_mode == MODE_SLEEPING) begin
                                    sq_ctl.remove = 1'b1;
                                    sq_ctl.id     = r_id;
                                end
                                cell_cmd.op  = COP_FREE;
                                cell_cmd.tid = r_id;
                                n_used_cnt   = r_used_cnt - 1'b1;
                            end
                        end
                    end
                    CMD_BLOCK: begin
                        if (r_id == '0) begin
                            n_status = STAT_MAIN_OP;
                        end else begin
                            n_status = chk;
                            if (chk == STAT_OK) begin
                                n_shown = RUN_W'(r_id);
                                if (is_runner) begin
                                    cell_cmd.op   = COP_MODE;
                                    cell_cmd.tid  = r_id;
                                    cell_cmd.mode = MODE_BLOCKED;
                                    n_pend        = PEND_BLOCK;
                                end else if (rd_mode == MODE_READY) begin
                                    rq_ctl.remove = 1'b1;
                                    rq_ctl.id     = r_id;
                                    cell_cmd.op   = COP_MODE;
                                    cell_cmd.tid  = r_id;
                                    cell_cmd.mode = MODE_BLOCKED;
                                end
                            end
                        end
                    end
                    CMD_RESUME: begin
                        n_status = chk;
                        if (chk == STAT_OK) begin
                            n_shown = RUN_W'(r_id);
                            if (rd_mode == MODE_BLOCKED) begin
                                cell_cmd.op  = COP_MODE;
                                cell_cmd.tid = r_id;
                                if (is_runner) begin
                                    cell_cmd.mode = MODE_RUNNING;
                                    n_pend        = PEND_ROUTINE;
                                end else begin
                                    cell_cmd.mode = MODE_READY;
                                    rq_ctl.push   = 1'b1;
                                    rq_ctl.id     = r_id;
                                end
                            end
                        end
                    end
                    CMD_SLEEP: begin
                        if (r_runner == '0) begin
                            n_status = STAT_MAIN_OP;
                        end else if (r_runner >= NO_RUNNER) begin
                            n_status = STAT_NO_ID;
                        end else begin
                            n_shown = r_runner;
                            if (r_q == '0) begin
                                n_status = STAT_BAD_INPUT;
                            end else begin
                                cell_cmd.op  = COP_SLEEP;
                                cell_cmd.tid = ID_W'(r_runner);
                                n_pend       = PEND_SLEEP;
                            end
                        end
                    end
                    CMD_TICK: begin
                        n_walk = '0;
                        n_old  = r_runner;
                    end
                    CMD_QUERY: begin
                        n_status = chk;
                        if (chk == STAT_OK) begin
                            n_shown = RUN_W'(r_id);
                        end
                    end
                    default: begin
                        n_status = STAT_BAD_INPUT;
                    end
                endcase
            end
            ST_WALK: begin
                // one sleeper per cycle; a woken entry closes up, so the index stays
                if (r_walk < sq_count) begin
                    cell_cmd.op  = COP_DEC;
                    cell_cmd.tid = ID_W'(sq_entry);
                    if (rd_wake <= QUANTA_W'(1)) begin
                        rq_ctl.push   = 1'b1;
                        rq_ctl.id     = ID_W'(sq_entry);
                        sq_ctl.remove = 1'b1;
                        sq_ctl.id     = ID_W'(sq_entry);
                    end else begin
                        n_walk = r_walk + 1'b1;
                    end
                end
            end
            ST_SETTLE: begin
                if (r_old < NO_RUNNER) begin
                    if (r_pend == PEND_SLEEP) begin
                        sq_ctl.push = 1'b1;
                        sq_ctl.id   = ID_W'(r_old);
                    end else if (r_pend == PEND_ROUTINE) begin
                        cell_cmd.op   = COP_MODE;
                        cell_cmd.tid  = ID_W'(r_old);
                        cell_cmd.mode = MODE_READY;
                        rq_ctl.push   = 1'b1;
                        rq_ctl.id     = ID_W'(r_old);
                    end
                end
                n_pend = PEND_ROUTINE;
            end
            ST_DISPATCH: begin
                if (rq_count == '0) begin
                    n_runner = NO_RUNNER;
                end else begin
                    rq_ctl.remove = 1'b1;
                    rq_ctl.id     = ID_W'(rq_head);
                    cell_cmd.op   = COP_DISPATCH;
                    cell_cmd.tid  = ID_W'(rq_head);
                    n_runner      = RUN_W'(rq_head);
                    if (r_total != '1) begin
                        n_total = r_total + 1'b1;
                    end
                end
                n_shown = n_runner;
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_limit    <= RUN_W'(MAX_THREADS);
            r_runner   <= '0;
            r_pend     <= PEND_ROUTINE;
            r_total    <= COUNT_WIDTH'(1);
            r_used_cnt <= RUN_W'(1);
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_runner   <= n_runner;
            r_pend     <= n_pend;
            r_total    <= n_total;
            r_used_cnt <= n_used_cnt;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_id  <= i_thread_id;
            r_q   <= i_sleep_quanta;
        end
        r_status <= n_status;
        r_asg    <= n_asg;
        r_shown  <= n_shown;
        r_walk   <= n_walk;
        r_old    <= n_old;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_asg    <= r_asg;
            r_o_run    <= r_runner;
            r_o_total  <= total64[OUT_CNT_W-1:0];
            r_o_tq     <= shown_ok ? rd_runs64[OUT_CNT_W-1:0] : '0;
            r_o_sl     <= (shown_ok && rd_mode == MODE_SLEEPING) ? rd_wake : '0;
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_ov;
    assign o_status        = r_o_status;
    assign o_assigned_id   = r_o_asg;
    assign o_running_id    = r_o_run;
    assign o_total_quanta  = r_o_total;
    assign o_thread_quanta = r_o_tq;
    assign o_sleep_left    = r_o_sl;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for round_robin_thread_scheduler_core.
// Depends on rrts_pkg and the scheduler RTL. An inline scheduler predictor checks every word.
`timescale 1ns / 1ps
module testbench;
    import rrts_pkg::*;

    localparam int NTH = 16;
    localparam logic [4:0] NONE = 5'd16;
    localparam int WDOG_LIMIT = 4000;

    typedef struct {
        logic [2:0] cmd;
        logic [5:0] tid;
        logic [15:0] quanta;
    } t_sched_cmd;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  asg;
        logic [4:0]  run;
        logic [31:0] total;
        logic [31:0] tq;
        logic [15:0] sl;
    } t_sched_word;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [4:0]  i_cfg_wr_data = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_cmd = 0;
    logic [5:0]  i_thread_id = 0;
    logic [15:0] i_sleep_quanta = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [3:0]  o_assigned_id;
    logic [4:0]  o_running_id;
    logic [31:0] o_total_quanta;
    logic [31:0] o_thread_quanta;
    logic [15:0] o_sleep_left;

    round_robin_thread_scheduler_core u_top (.*);

    always #5 i_clk = ~i_clk;

    t_sched_cmd  cmd_q[$];
    t_sched_word want_q[$];
    bit          fails = 0;
    bit          no_idle = 0;
    int          wdog = 0;

    // scheduler shadow state
    logic [4:0]  lim_reg = 5'd16;
    bit          used[NTH];
    logic [1:0]  mode[NTH];
    logic [31:0] runs[NTH];
    logic [15:0] wake[NTH];
    int          ready_q[$];
    int          sleep_q[$];
    logic [4:0]  runner;
    logic [1:0]  pend;
    logic [31:0] total;

    function automatic int eff_lim();
        if (lim_reg == 0) return 1;
        if (lim_reg > NTH) return NTH;
        return lim_reg;
    endfunction

    function automatic logic [31:0] sat(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function automatic void drop(ref int q[$], input int id);
        int keep[$];
        foreach (q[i]) if (q[i] != id) keep = {keep, q[i]};
        q = keep;
    endfunction

    function automatic void sched_clear();
        for (int i = 0; i < NTH; i++) begin
            used[i] = 0; mode[i] = MODE_READY; runs[i] = 0; wake[i] = 0;
        end
        ready_q.delete();
        sleep_q.delete();
        used[0] = 1; mode[0] = MODE_RUNNING; runs[0] = 1;
        runner = 0; pend = PEND_ROUTINE; total = 1;
    endfunction

    function automatic logic [2:0] id_status(int id);
        if (id >= eff_lim()) return STAT_RANGE;
        if (!used[id]) return STAT_NO_ID;
        return STAT_OK;
    endfunction

    function automatic t_sched_word sched_step(t_sched_cmd c);
        t_sched_word w;
        int shown, id, nused, slot, old, h;
        int keep[$];
        w.status = STAT_OK; w.asg = 0; w.tq = 0; w.sl = 0;
        shown = NTH;
        id = c.tid;
        case (c.cmd)
            CMD_SPAWN: begin
                nused = 0;
                for (int i = 0; i < NTH; i++) nused += used[i];
                slot = eff_lim();
                for (int i = eff_lim() - 1; i >= 0; i--) if (!used[i]) slot = i;
                if (nused >= eff_lim() || slot >= eff_lim()) w.status = STAT_TOO_MANY;
                else begin
                    used[slot] = 1; mode[slot] = MODE_READY; runs[slot] = 0; wake[slot] = 0;
                    if (ready_q.size() < NTH) ready_q = {ready_q, slot};
                    w.asg = 4'(slot); shown = slot;
                end
            end
            CMD_TERM: begin
                if (id == 0) begin
                    sched_clear(); w.status = STAT_MAIN_EXIT; shown = 0;
                end else begin
                    w.status = id_status(id);
                    if (w.status == STAT_OK) begin
                        if (id == runner) begin
                            runner = NONE; pend = PEND_REMOVE;
                        end else if (mode[id] == MODE_READY) drop(ready_q, id);
                        else if (mode[id] == MODE_SLEEPING) drop(sleep_q, id);
                        used[id] = 0; mode[id] = MODE_READY; runs[id] = 0; wake[id] = 0;
                    end
                end
            end
            CMD_BLOCK: begin
                if (id == 0) w.status = STAT_MAIN_OP;
                else begin
                    w.status = id_status(id);
                    if (w.status == STAT_OK) begin
                        shown = id;
                        if (id == runner) begin
                            mode[id] = MODE_BLOCKED; wake[id] = 0; pend = PEND_BLOCK;
                        end else if (mode[id] == MODE_READY) begin
                            drop(ready_q, id); mode[id] = MODE_BLOCKED;
                        end
                    end
                end
            end
            CMD_RESUME: begin
                w.status = id_status(id);
                if (w.status == STAT_OK) begin
                    shown = id;
                    if (mode[id] == MODE_BLOCKED) begin
                        if (id == runner) begin
                            mode[id] = MODE_RUNNING; pend = PEND_ROUTINE;
                        end else begin
                            mode[id] = MODE_READY;
                            if (ready_q.size() < NTH) ready_q = {ready_q, id};
                        end
                    end
                end
            end
            CMD_SLEEP: begin
                if (runner == 0) w.status = STAT_MAIN_OP;
                else if (runner >= NTH) w.status = STAT_NO_ID;
                else begin
                    shown = runner;
                    if (c.quanta == 0) w.status = STAT_BAD_INPUT;
                    else begin
                        mode[runner] = MODE_SLEEPING; wake[runner] = c.quanta;
                        pend = PEND_SLEEP;
                    end
                end
            end
            CMD_TICK: begin
                old = runner;
                foreach (sleep_q[i]) begin
                    h = sleep_q[i];
                    if (wake[h] > 0) wake[h]--;
                    if (wake[h] == 0) begin
                        mode[h] = MODE_READY;
                        if (ready_q.size() < NTH) ready_q = {ready_q, h};
                    end else keep = {keep, h};
                end
                sleep_q = keep;
                if (old < NTH) begin
                    if (pend == PEND_SLEEP) begin
                        if (sleep_q.size() < NTH) sleep_q = {sleep_q, old};
                    end else if (pend == PEND_ROUTINE) begin
                        mode[old] = MODE_READY;
                        if (ready_q.size() < NTH) ready_q = {ready_q, old};
                    end
                end
                pend = PEND_ROUTINE;
                if (ready_q.size() == 0) runner = NONE;
                else begin
                    h = ready_q[0];
                    drop(ready_q, h);
                    runner = 5'(h); mode[h] = MODE_RUNNING;
                    runs[h] = sat(runs[h]); total = sat(total);
                end
                shown = runner;
            end
            CMD_QUERY: begin
                w.status = id_status(id);
                if (w.status == STAT_OK) shown = id;
            end
            default: w.status = STAT_BAD_INPUT;
        endcase
        if (shown < NTH && used[shown]) begin
            w.tq = runs[shown];
            w.sl = (mode[shown] == MODE_SLEEPING) ? wake[shown] : 0;
        end
        w.run = runner;
        w.total = total;
        return w;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 28);
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                t_sched_cmd c;
                c.cmd = i_cmd; c.tid = i_thread_id; c.quanta = i_sleep_quanta;
                want_q = {want_q, sched_step(c)};
            end
            if (!i_valid || !o_stall) begin
                if (cmd_q.size() > 0 && !idle_now()) begin
                    t_sched_cmd n;
                    n = cmd_q.pop_front();
                    i_cmd <= n.cmd; i_thread_id <= n.tid; i_sleep_quanta <= n.quanta;
                    i_valid <= 1;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (want_q.size() == 0) begin
                    $error("unexpected result word, status %0d", o_status);
                    fails = 1;
                end else begin
                    t_sched_word e;
                    e = want_q.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); fails = 1;
                    end
                    if (o_assigned_id !== e.asg) begin
                        $error("assigned_id exp %0d got %0d", e.asg, o_assigned_id); fails = 1;
                    end
                    if (o_running_id !== e.run) begin
                        $error("running_id exp %0d got %0d", e.run, o_running_id); fails = 1;
                    end
                    if (o_total_quanta !== e.total) begin
                        $error("total_quanta exp %0d got %0d", e.total, o_total_quanta);
                        fails = 1;
                    end
                    if (o_thread_quanta !== e.tq) begin
                        $error("thread_quanta exp %0d got %0d", e.tq, o_thread_quanta);
                        fails = 1;
                    end
                    if (o_sleep_left !== e.sl) begin
                        $error("sleep_left exp %0d got %0d", e.sl, o_sleep_left); fails = 1;
                    end
                end
            end
            i_stall <= idle_now();
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) wdog <= 0;
        else if (i_valid || cmd_q.size() > 0 || want_q.size() > 0) wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add(logic [2:0] c, logic [5:0] id, logic [15:0] q);
        t_sched_cmd n;
        n.cmd = c; n.tid = id; n.quanta = q;
        cmd_q = {cmd_q, n};
    endtask

    task automatic set_limit(logic [4:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        lim_reg = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || i_valid || want_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        int r, lim;
        logic [5:0] id;
        logic [15:0] q;
        lim = eff_lim();
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, lim + 1));
            case ($urandom_range(0, 9))
                0: q = 0;
                1: q = 16'($urandom_range(0, 65535));
                2: q = 16'hFFFF;
                default: q = 16'($urandom_range(1, 4));
            endcase
            if (r < 20) add(CMD_SPAWN, id, q);
            else if (r < 27) add(CMD_TERM, (id == 0 && $urandom_range(0, 3) != 0) ? 6'd1 : id, q);
            else if (r < 38) add(CMD_BLOCK, id, q);
            else if (r < 49) add(CMD_RESUME, id, q);
            else if (r < 59) add(CMD_SLEEP, id, q);
            else if (r < 86) add(CMD_TICK, id, q);
            else if (r < 98) add(CMD_QUERY, id, q);
            else add(3'd7, id, q);
        end
    endtask

    initial begin
        logic [4:0] limits[8];
        limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd16, 5'd5};
        sched_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        set_limit(5'd4);
        // directed: error codes, sleep/block of runner, wakeups, main exit
        add(CMD_SPAWN, 0, 0); add(CMD_SPAWN, 0, 0); add(CMD_SPAWN, 0, 0);
        add(CMD_SPAWN, 0, 0);
        add(CMD_QUERY, 6'd63, 0); add(CMD_QUERY, 6'd4, 0); add(CMD_BLOCK, 0, 0);
        add(CMD_SLEEP, 0, 5); add(CMD_TICK, 0, 0);
        add(CMD_SLEEP, 0, 0); add(CMD_SLEEP, 0, 16'hFFFF); add(CMD_TICK, 0, 0);
        add(CMD_BLOCK, 6'd2, 0); add(CMD_RESUME, 6'd2, 0); add(CMD_BLOCK, 6'd2, 0);
        add(CMD_TICK, 0, 0); add(CMD_RESUME, 6'd2, 0); add(CMD_TERM, 6'd3, 0);
        add(CMD_TICK, 0, 0); add(CMD_TERM, 6'd1, 0); add(CMD_SLEEP, 0, 1);
        add(CMD_TICK, 0, 0); add(CMD_QUERY, 6'd1, 0); add(3'd7, 6'd63, 16'hFFFF);
        add(CMD_TERM, 6'd0, 0);
        drain();
        foreach (limits[p]) begin
            set_limit(limits[p]);
            no_idle = (p == 6);
            add_random(245);
            drain();
        end
        if (fails) begin
            $display("Test completed with failures");
        end else begin
            $display("Test completed successfully");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/rrts_pkg.sv
rtl/rrts_thread_cell.sv
rtl/rrts_queue_cell.sv
rtl/rrts_queue.sv
rtl/round_robin_thread_scheduler_core.sv
bench/testbench.sv
